>>> rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants of the circular array deque
// Sizes, command and status codes, and the control group that drives a cell.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

   // Number of cells and width of a stored word.
   localparam int DEPTH      = 16;
   localparam int WORD_WIDTH = 32;

   // Widths of the request and response fields.
   localparam int DATA_W = 32;
   localparam int CMD_W  = 2;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 5;

   // A cell keeps only the bits that can reach the response.
   localparam int CELL_W = (WORD_WIDTH < DATA_W) ? WORD_WIDTH : DATA_W;

   // The occupancy counter has to hold DEPTH itself.
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_HEAD = 2'd0,
      CMD_PUSH_TAIL = 2'd1,
      CMD_POP_HEAD  = 2'd2,
      CMD_POP_TAIL  = 2'd3
   } cmd_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE      = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   // Per-cell control for one cycle.
   typedef struct packed {
      logic from_left;   // take the word of the cell toward the head
      logic from_right;  // take the word of the cell toward the tail
      logic load;        // take the request word
      logic rd_sel;      // drive the stored word onto the read bus
   } cell_ctl_type;

endpackage

`default_nettype wire

>>> rtl/cdq_cell.sv
// ----------------------------------------------------------------------------
// cdq_cell: one storage cell of the deque chain
// Holds one word and takes a neighbor's word, the request word, or its own.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_cell
   import cdq_pkg::*;
(
   input  wire logic              clock,
   input  wire cell_ctl_type      ctl,
   input  wire logic [CELL_W-1:0] left_word,
   input  wire logic [CELL_W-1:0] right_word,
   input  wire logic [CELL_W-1:0] load_word,
   output logic      [CELL_W-1:0] word,
   output logic      [CELL_W-1:0] rd_word
);

   logic [CELL_W-1:0] word_ff;
   logic [CELL_W-1:0] word_in;

   always_comb begin
      if (ctl.from_left) begin
         word_in = left_word;
      end else if (ctl.from_right) begin
         word_in = right_word;
      end else if (ctl.load) begin
         word_in = load_word;
      end else begin
         word_in = word_ff;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word    = word_ff;
   assign rd_word = ctl.rd_sel ? word_ff : '0;

endmodule

`default_nettype wire

>>> rtl/circular_array_deque.sv
// ----------------------------------------------------------------------------
// circular_array_deque: double-ended queue built as a chain of word cells
// Insert and remove at either end; every command answers with one response.
// ----------------------------------------------------------------------------
//
//   Channel    | Handshake              | Payload
//   -----------+------------------------+----------------------------------
//   request    | start in, busy out     | req_cmd, req_data_in
//   response   | rsp_strobe out         | rsp_data_out, rsp_status,
//              |                        | rsp_now_empty, rsp_now_full,
//              |                        | rsp_occupancy
//
// A command is taken at a rising edge with start high and busy low. Its
// response appears on the rsp_ ports for exactly one cycle, the cycle right
// after the command was taken, with rsp_strobe high. Every cell computes
// its next word from its two neighbors in the same cycle, so a command can
// follow in every cycle outside reset.
// Reset is synchronous and active high; busy is high while reset is high.
// Reset empties the deque; the words in the cells are left as they were.
// The receiver has no way to stall a response, and the block needs none.
//
// The deque is held head-aligned: cell 0 always has the head word and cell
// count-1 has the tail word. An insert at the head shifts every cell one
// place toward the tail; a removal at the head shifts one place back. An
// insert at the tail loads only the cell at position count, and a removal
// at the tail just lowers the count. Removals read through a one-hot read
// bus that the selected cell drives.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_array_deque
   import cdq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire logic [CMD_W-1:0]  req_cmd,
   input  wire logic [DATA_W-1:0] req_data_in,
   output logic                   rsp_strobe,
   output logic [DATA_W-1:0]      rsp_data_out,
   output logic [STAT_W-1:0]      rsp_status,
   output logic                   rsp_now_empty,
   output logic                   rsp_now_full,
   output logic [OCC_W-1:0]       rsp_occupancy
);

   // Registers.
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              strobe_ff, strobe_in;
   logic [DATA_W-1:0] data_out_ff, data_out_in;
   status_type        status_ff, status_in;

   // Decode of the command taken in this cycle.
   logic       accept;
   cmd_type    cmd;
   logic       is_full;
   logic       is_empty;
   logic       do_push_head;
   logic       do_push_tail;
   logic       do_pop_head;
   logic       do_pop_tail;
   logic [CNT_W-1:0] tail_pos;

   // Cell chain wiring.
   logic [CELL_W-1:0] req_word;
   cell_ctl_type      cell_ctl  [DEPTH];
   logic [CELL_W-1:0] cell_word [DEPTH];
   logic [CELL_W-1:0] cell_rd   [DEPTH];
   logic [CELL_W-1:0] rd_bus;
   logic [DATA_W-1:0] rd_ext;

   // The block can take a command in every cycle outside reset.
   assign busy = reset;

   assign accept   = start & ~busy;
   assign cmd      = cmd_type'(req_cmd);
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_empty = (count_ff == '0);
   assign tail_pos = count_ff - CNT_W'(1);
   assign req_word = req_data_in[CELL_W-1:0];

   assign do_push_head = accept & (cmd == CMD_PUSH_HEAD) & ~is_full;
   assign do_push_tail = accept & (cmd == CMD_PUSH_TAIL) & ~is_full;
   assign do_pop_head  = accept & (cmd == CMD_POP_HEAD)  & ~is_empty;
   assign do_pop_tail  = accept & (cmd == CMD_POP_TAIL)  & ~is_empty;

   // The chain. Cell 0 sees the request word as its head-side neighbor so a
   // head insert is a plain shift; the last cell sees itself on the far side.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [CELL_W-1:0] left_word;
      logic [CELL_W-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = req_word;
      end else begin : g_inner_left
         assign left_word = cell_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_word = cell_word[i];
      end else begin : g_inner_right
         assign right_word = cell_word[i+1];
      end

      assign cell_ctl[i].from_left  = do_push_head;
      assign cell_ctl[i].from_right = do_pop_head;
      assign cell_ctl[i].load       = do_push_tail & (count_ff == CNT_W'(i));
      assign cell_ctl[i].rd_sel     = (do_pop_head & (i == 0)) |
                                      (do_pop_tail & (tail_pos == CNT_W'(i)));

      cdq_cell u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[i]),
         .left_word  (left_word),
         .right_word (right_word),
         .load_word  (req_word),
         .word       (cell_word[i]),
         .rd_word    (cell_rd[i])
      );
   end

   // At most one cell drives the read bus, so the others add zeros.
   always_comb begin
      rd_bus = '0;
      for (int j = 0; j < DEPTH; j++) begin
         rd_bus = rd_bus | cell_rd[j];
      end
   end

   if (CELL_W == DATA_W) begin : g_rd_full
      assign rd_ext = rd_bus;
   end else begin : g_rd_pad
      assign rd_ext = {(DATA_W - CELL_W)'(0), rd_bus};
   end

   // Next state and response.
   always_comb begin
      count_in    = count_ff;
      strobe_in   = accept;
      data_out_in = data_out_ff;
      status_in   = status_ff;
      if (accept) begin
         data_out_in = rd_ext;
         status_in   = ST_DONE;
         case (cmd)
            CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
               if (is_full) begin
                  status_in = ST_OVERFLOW;
               end else begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
            CMD_POP_HEAD, CMD_POP_TAIL: begin
               if (is_empty) begin
                  status_in = ST_UNDERFLOW;
               end else begin
                  count_in = count_ff - CNT_W'(1);
               end
            end
            default: begin
               status_in = ST_DONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
      data_out_ff <= data_out_in;
      status_ff   <= status_in;
   end

   // The flags follow the count, which has already taken the command.
   assign rsp_strobe    = strobe_ff;
   assign rsp_data_out  = data_out_ff;
   assign rsp_status    = status_ff;
   assign rsp_now_empty = (count_ff == '0);
   assign rsp_now_full  = (count_ff == CNT_W'(DEPTH));

   // Occupancy is reported in a fixed five bits and wraps for deep chains.
   if (CNT_W >= OCC_W) begin : g_occ_cut
      assign rsp_occupancy = count_ff[OCC_W-1:0];
   end else begin : g_occ_pad
      assign rsp_occupancy = {(OCC_W - CNT_W)'(0), count_ff};
   end

endmodule

`default_nettype wire

>>> rtl/cdq_checker.sv
// ----------------------------------------------------------------------------
// cdq_checker: port-level checks of the circular array deque
// Watches the top-level ports and flags responses that break the contract.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_checker
   import cdq_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              start,
   input wire logic              busy,
   input wire logic [CMD_W-1:0]  req_cmd,
   input wire logic              rsp_strobe,
   input wire logic [DATA_W-1:0] rsp_data_out,
   input wire logic [STAT_W-1:0] rsp_status,
   input wire logic              rsp_now_empty,
   input wire logic              rsp_now_full,
   input wire logic [OCC_W-1:0]  rsp_occupancy
);

   // Every taken command gets exactly one response in the next cycle.
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_strobe)
      else $error("command taken without a response");

   a_no_extra_rsp: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_strobe)
      else $error("response without a command");

   // A refused insert leaves the deque full.
   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_OVERFLOW) |-> rsp_now_full)
      else $error("overflow reported while not full");

   // A refused removal leaves the deque empty and returns no word.
   a_underflow_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_UNDERFLOW) |->
         (rsp_now_empty && rsp_data_out == '0 && rsp_occupancy == '0))
      else $error("underflow reported with entries or data");

   // An insert that went through cannot leave the deque empty.
   a_push_not_empty: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_cmd == CMD_PUSH_HEAD || req_cmd == CMD_PUSH_TAIL))
         |=> !rsp_now_empty)
      else $error("deque empty after an insert");

endmodule

bind circular_array_deque cdq_checker u_cdq_checker (.*);

`default_nettype wire

>>> sim/circular_array_deque_test.sv
// ----------------------------------------------------------------------------
// circular_array_deque_test: self-checking bench for the circular array deque
// Drives insert and remove commands at both ends through the start/busy port.
// Every response is checked against a behavioral deque kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module circular_array_deque_test;
   import cdq_pkg::*;

   // The run is stopped here no matter what, so a hung block cannot stall it.
   localparam int CYCLE_LIMIT = 400000;
   // Number of random commands after the directed opening.
   localparam int RANDOM_CMDS = 1700;
   // Room for every command the bench lines up, directed and random.
   localparam int CMD_SLOTS = 4096;
   // Responses in flight at one time; one is the most the block can owe.
   localparam int ANSWER_SLOTS = 8;
   // Only the low WORD_WIDTH bits of an inserted word are kept by the block.
   localparam logic [DATA_W-1:0] WORD_MASK = {DATA_W{1'b1}} >> (DATA_W - CELL_W);

   // One command waiting to be driven, with the idle cycles that follow it.
   typedef struct {
      cmd_type          op;
      logic [DATA_W-1:0] word;
      int unsigned      gap;
   } deque_cmd_type;

   // Everything the block reports for one command.
   typedef struct packed {
      logic [DATA_W-1:0] data_out;
      logic [STAT_W-1:0] status;
      logic              now_empty;
      logic              now_full;
      logic [OCC_W-1:0]  occupancy;
   } deque_answer_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [CMD_W-1:0]  req_cmd = CMD_PUSH_HEAD;
   logic [DATA_W-1:0] req_data_in = '0;
   logic              rsp_strobe;
   logic [DATA_W-1:0] rsp_data_out;
   logic [STAT_W-1:0] rsp_status;
   logic              rsp_now_empty;
   logic              rsp_now_full;
   logic [OCC_W-1:0]  rsp_occupancy;

   // Commands in order; the driver hands out the one at cmd_next.
   deque_cmd_type     cmd_list [CMD_SLOTS];
   int unsigned       cmd_count = 0;
   int unsigned       cmd_next = 0;
   // Responses the block still owes, oldest at due_rd.
   deque_answer_type  answers_due [ANSWER_SLOTS];
   int unsigned       due_wr = 0;
   int unsigned       due_rd = 0;
   // The bench's own picture of the deque: a ring with a head slot and a count.
   logic [DATA_W-1:0] model_words [DEPTH];
   int unsigned       model_head = 0;
   int unsigned       model_count = 0;

   // Set at a rising edge where the block took the word on the request port.
   logic        word_taken = 1'b0;
   int unsigned hold_off = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned cmds_taken = 0;
   int unsigned overflow_count = 0;
   int unsigned underflow_count = 0;
   int unsigned full_visits = 0;
   int unsigned empty_visits = 0;

   circular_array_deque u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_cmd       (req_cmd),
      .req_data_in   (req_data_in),
      .rsp_strobe    (rsp_strobe),
      .rsp_data_out  (rsp_data_out),
      .rsp_status    (rsp_status),
      .rsp_now_empty (rsp_now_empty),
      .rsp_now_full  (rsp_now_full),
      .rsp_occupancy (rsp_occupancy)
   );

   // 8 ns clock period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Behavioral deque. It applies one command to the bench's copy of the
   // contents and returns the response the block must give for it. Refused
   // commands leave the contents alone; data_out is zero unless a word was
   // actually removed.
   function automatic deque_answer_type deque_apply(cmd_type op, logic [DATA_W-1:0] word);
      deque_answer_type ans;
      int unsigned      slot;
      ans = '0;
      ans.status = ST_DONE;
      case (op)
         CMD_PUSH_HEAD, CMD_PUSH_TAIL: begin
            if (model_count == DEPTH) begin
               ans.status = ST_OVERFLOW;
               overflow_count++;
            end else if (op == CMD_PUSH_HEAD) begin
               model_head = (model_head + DEPTH - 1) % DEPTH;
               model_words[model_head] = word & WORD_MASK;
               model_count++;
            end else begin
               slot = (model_head + model_count) % DEPTH;
               model_words[slot] = word & WORD_MASK;
               model_count++;
            end
         end
         default: begin
            if (model_count == 0) begin
               ans.status = ST_UNDERFLOW;
               underflow_count++;
            end else if (op == CMD_POP_HEAD) begin
               ans.data_out = model_words[model_head];
               model_head = (model_head + 1) % DEPTH;
               model_count--;
            end else begin
               slot = (model_head + model_count - 1) % DEPTH;
               ans.data_out = model_words[slot];
               model_count--;
            end
         end
      endcase
      ans.now_empty = (model_count == 0);
      ans.now_full  = (model_count == DEPTH);
      ans.occupancy = OCC_W'(model_count);
      if (ans.now_full)
         full_visits++;
      if (ans.now_empty)
         empty_visits++;
      return ans;
   endfunction

   task automatic flag_field(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $realtime, field, want, got);
      end
   endtask

   task automatic queue_cmd(cmd_type op, logic [DATA_W-1:0] word, int unsigned gap);
      deque_cmd_type item;
      item.op = op;
      item.word = word;
      item.gap = gap;
      cmd_list[cmd_count] = item;
      cmd_count++;
   endtask

   // Mostly back-to-back, some short pauses, a few long ones.
   function automatic int unsigned pick_gap(bit idle_on);
      int unsigned roll;
      roll = $urandom_range(99);
      if (!idle_on || roll < 65)
         return 0;
      if (roll < 95)
         return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Random words, with the signed extremes and the all-zero and all-one
   // patterns thrown in now and then.
   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(19))
         0:       return {1'b0, {(DATA_W-1){1'b1}}};
         1:       return {1'b1, {(DATA_W-1){1'b0}}};
         2:       return '0;
         3:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Driver. The request port changes only on falling edges. A command stays
   // on the port until the block takes it, then the idle gap that came with
   // it runs before the next one goes out.
   always @(negedge clock) begin : feed
      deque_cmd_type item;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || word_taken) begin
         if (hold_off > 0) begin
            start <= 1'b0;
            hold_off <= hold_off - 1;
         end else if (cmd_next < cmd_count) begin
            item = cmd_list[cmd_next];
            cmd_next <= cmd_next + 1;
            start <= 1'b1;
            req_cmd <= item.op;
            req_data_in <= item.word;
            hold_off <= item.gap;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor. A response belongs to a command taken at an earlier edge, so
   // the response is checked first and only then is the command taken at
   // this edge turned into a new expectation.
   always @(posedge clock) begin : watch
      deque_answer_type want;
      deque_answer_type got;
      word_taken <= start && !busy;
      if (!reset && rsp_strobe !== 1'b0) begin
         got = {rsp_data_out, rsp_status, rsp_now_empty, rsp_now_full, rsp_occupancy};
         if (due_wr == due_rd) begin
            error_count++;
            $display("%0t: response with none expected, expected nothing, got %h",
                     $realtime, got);
         end else begin
            want = answers_due[due_rd % ANSWER_SLOTS];
            due_rd++;
            flag_field("data_out",  want.data_out,             got.data_out);
            flag_field("status",    DATA_W'(want.status),    DATA_W'(got.status));
            flag_field("now_empty", DATA_W'(want.now_empty), DATA_W'(got.now_empty));
            flag_field("now_full",  DATA_W'(want.now_full),  DATA_W'(got.now_full));
            flag_field("occupancy", DATA_W'(want.occupancy), DATA_W'(got.occupancy));
         end
      end
      if (!reset && start && !busy) begin
         cmds_taken++;
         answers_due[due_wr % ANSWER_SLOTS] = deque_apply(cmd_type'(req_cmd), req_data_in);
         due_wr++;
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: run did not finish within %0d cycles", $realtime, CYCLE_LIMIT);
         $display("[circular_array_deque] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned made;
      int unsigned phase_len;
      int unsigned push_pct;
      bit          idle_on;
      bit          is_push;
      bit          at_head;
      cmd_type     op;

      // Directed opening. Removals from an empty deque at both ends must be
      // refused with underflow.
      queue_cmd(CMD_POP_HEAD, 32'h1234_5678, 0);
      queue_cmd(CMD_POP_TAIL, 32'hFFFF_FFFF, 0);
      // Insert into an empty deque, then remove that last entry from the
      // other end, and the same the other way round.
      queue_cmd(CMD_PUSH_HEAD, 32'h7FFF_FFFF, 0);
      queue_cmd(CMD_POP_TAIL, 32'h0000_0000, 0);
      queue_cmd(CMD_PUSH_TAIL, 32'h8000_0000, 1);
      queue_cmd(CMD_POP_HEAD, 32'h5555_5555, 0);
      // Fill from both ends so the indices wrap, until the deque is full.
      for (int i = 0; i < DEPTH; i++) begin
         if (i % 2 == 0)
            queue_cmd(CMD_PUSH_HEAD, (i % 4 == 0) ? 32'hAAAA_AAAA : 32'h0000_0000, 0);
         else
            queue_cmd(CMD_PUSH_TAIL, (i % 4 == 1) ? 32'h5555_5555 : 32'hFFFF_FFFF, 0);
      end
      // Inserts into a full deque are refused with overflow at either end.
      queue_cmd(CMD_PUSH_HEAD, 32'hDEAD_0001, 0);
      queue_cmd(CMD_PUSH_TAIL, 32'hDEAD_0002, 0);
      queue_cmd(CMD_POP_TAIL, 32'h0000_0000, 2);

      // Random part in phases: some lean toward inserts and run the deque
      // full, some lean toward removals and drain it, some are balanced.
      // Some phases run with no idle cycles at all.
      made = 0;
      while (made < RANDOM_CMDS) begin
         phase_len = $urandom_range(160, 40);
         push_pct = $urandom_range(2) * 30 + 20;
         idle_on = ($urandom_range(3) != 0);
         for (int i = 0; i < phase_len && made < RANDOM_CMDS; i++) begin
            is_push = ($urandom_range(99) < push_pct);
            at_head = $urandom_range(1);
            if (is_push)
               op = at_head ? CMD_PUSH_HEAD : CMD_PUSH_TAIL;
            else
               op = at_head ? CMD_POP_HEAD : CMD_POP_TAIL;
            queue_cmd(op, pick_word(), pick_gap(idle_on));
            made++;
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every command went out and every response came back.
      while (cmd_next < cmd_count || start || hold_off > 0 || due_wr != due_rd)
         @(posedge clock);
      // A few more cycles to catch any stray response.
      repeat (4) @(posedge clock);

      if (due_wr != due_rd) begin
         error_count++;
         $display("%0t: %0d responses never arrived, expected none left, got %0d left",
                  $realtime, due_wr - due_rd, due_wr - due_rd);
      end

      $display("Checked %0d deque commands: %0d overflow and %0d underflow refusals,",
               cmds_taken, overflow_count, underflow_count);
      $display("the deque was left full %0d times and empty %0d times.",
               full_visits, empty_visits);
      if (error_count == 0) begin
         $display("[circular_array_deque] OK");
      end else begin
         $display("[circular_array_deque] ERROR");
      end
      $finish;
   end

endmodule
